// ----- hdl/rmq_pkg.sv -----
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants for the matrix to quaternion pipeline
// Widths of the square-root and divider pipelines and the case codes.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int FRAC_BITS_DEF = 30;

  // entry and result width
  localparam int DATA_W = 32;
  // sign-extended sums of ONE and up to three entries
  localparam int ARG_W  = 35;
  // magnitude of a sum or difference of two entries
  localparam int MAG_W  = 33;

  // square root: 64-bit radicand, 32-bit root, one root bit per stage
  localparam int RAD_W    = 64;
  localparam int ROOT_W   = 32;
  localparam int SQ_STEPS = ROOT_W;
  localparam int SQ_REM_W = ROOT_W + 2;

  // divider: 64-bit dividend, 33-bit divisor, one quotient bit per stage
  localparam int DIVD_W   = 64;
  localparam int DIVS_W   = ROOT_W + 1;
  localparam int Q_W      = 32;
  localparam int DV_STEPS = Q_W;
  localparam int DV_LAT   = DV_STEPS + 1;

  // accept edge to the edge that takes the result
  localparam int LATENCY = 3 + SQ_STEPS + 1 + DV_LAT + 1;

  typedef enum logic [1:0] {
    CASE_TRACE = 2'd0,
    CASE_X     = 2'd1,
    CASE_Y     = 2'd2,
    CASE_Z     = 2'd3
  } case_t;

endpackage

// ----- hdl/rmq_sqrt.sv -----
// ----------------------------------------------------------------------------
// rmq_sqrt: pipelined integer square root
// Restoring digit recurrence, one root bit per stage, one word per cycle.
// ----------------------------------------------------------------------------
module rmq_sqrt
  import rmq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  rad,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root
);

  logic                vld     [SQ_STEPS];
  logic [SQ_REM_W-1:0] rem_q   [SQ_STEPS];
  logic [ROOT_W-1:0]   root_q  [SQ_STEPS];
  logic [RAD_W-1:0]    rad_q   [SQ_STEPS];

  logic [SQ_REM_W-1:0] rem_in  [SQ_STEPS];
  logic [ROOT_W-1:0]   root_in [SQ_STEPS];
  logic [RAD_W-1:0]    rad_in  [SQ_STEPS];
  logic [SQ_REM_W+1:0] cur     [SQ_STEPS];
  logic [SQ_REM_W+1:0] trial   [SQ_STEPS];

  genvar j;
  generate
    for (j = 0; j < SQ_STEPS; j++) begin : g_step
      if (j == 0) begin : g_first
        assign rem_in[j]  = '0;
        assign root_in[j] = '0;
        assign rad_in[j]  = rad;
      end else begin : g_next
        assign rem_in[j]  = rem_q[j-1];
        assign root_in[j] = root_q[j-1];
        assign rad_in[j]  = rad_q[j-1];
      end

      // bring down two radicand bits and try root*4+1
      assign cur[j]   = {rem_in[j], rad_in[j][RAD_W-1 -: 2]};
      assign trial[j] = {2'b00, root_in[j], 2'b01};

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[j] <= 1'b0;
        end else begin
          vld[j] <= (j == 0) ? in_valid : vld[(j == 0) ? 0 : j-1];
        end
        rad_q[j] <= {rad_in[j][RAD_W-3:0], 2'b00};
        if (cur[j] >= trial[j]) begin
          rem_q[j]  <= SQ_REM_W'(cur[j] - trial[j]);
          root_q[j] <= {root_in[j][ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[j]  <= cur[j][SQ_REM_W-1:0];
          root_q[j] <= {root_in[j][ROOT_W-2:0], 1'b0};
        end
      end
    end
  endgenerate

  assign out_valid = vld[SQ_STEPS-1];
  assign root      = root_q[SQ_STEPS-1];

endmodule

// ----- hdl/rmq_div.sv -----
// ----------------------------------------------------------------------------
// rmq_div: pipelined unsigned divider with saturation
// Entry stage flags a quotient of 2^32 or more, then one quotient bit per
// stage. The magnitude comes out clamped to 2^31.
// ----------------------------------------------------------------------------
module rmq_div
  import rmq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              out_valid,
  output logic [Q_W-1:0]    quot
);

  localparam int LOW_W = DIVD_W - Q_W;

  // entry stage
  logic              e_vld;
  logic              e_ovf;
  logic [DIVS_W-1:0] e_rem;
  logic [Q_W-1:0]    e_low;
  logic [DIVS_W-1:0] e_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else begin
      e_vld <= in_valid;
    end
    e_ovf <= DIVS_W'(dividend[DIVD_W-1 -: LOW_W]) >= divisor;
    e_rem <= DIVS_W'(dividend[DIVD_W-1 -: LOW_W]);
    e_low <= dividend[Q_W-1:0];
    e_div <= divisor;
  end

  logic              vld    [DV_STEPS];
  logic              ovf_q  [DV_STEPS];
  logic [DIVS_W-1:0] rem_q  [DV_STEPS];
  logic [Q_W-1:0]    low_q  [DV_STEPS];
  logic [Q_W-1:0]    q_q    [DV_STEPS];
  logic [DIVS_W-1:0] div_q  [DV_STEPS];

  logic              vld_in [DV_STEPS];
  logic              ovf_in [DV_STEPS];
  logic [DIVS_W-1:0] rem_in [DV_STEPS];
  logic [Q_W-1:0]    low_in [DV_STEPS];
  logic [Q_W-1:0]    q_in   [DV_STEPS];
  logic [DIVS_W-1:0] div_in [DV_STEPS];
  logic [DIVS_W:0]   cur    [DV_STEPS];

  genvar j;
  generate
    for (j = 0; j < DV_STEPS; j++) begin : g_step
      if (j == 0) begin : g_first
        assign vld_in[j] = e_vld;
        assign ovf_in[j] = e_ovf;
        assign rem_in[j] = e_rem;
        assign low_in[j] = e_low;
        assign q_in[j]   = '0;
        assign div_in[j] = e_div;
      end else begin : g_next
        assign vld_in[j] = vld[j-1];
        assign ovf_in[j] = ovf_q[j-1];
        assign rem_in[j] = rem_q[j-1];
        assign low_in[j] = low_q[j-1];
        assign q_in[j]   = q_q[j-1];
        assign div_in[j] = div_q[j-1];
      end

      // shift in the next dividend bit and subtract where it fits
      assign cur[j] = {rem_in[j], low_in[j][Q_W-1]};

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[j] <= 1'b0;
        end else begin
          vld[j] <= vld_in[j];
        end
        ovf_q[j] <= ovf_in[j];
        low_q[j] <= {low_in[j][Q_W-2:0], 1'b0};
        div_q[j] <= div_in[j];
        if (cur[j] >= {1'b0, div_in[j]}) begin
          rem_q[j] <= DIVS_W'(cur[j] - {1'b0, div_in[j]});
          q_q[j]   <= {q_in[j][Q_W-2:0], 1'b1};
        end else begin
          rem_q[j] <= cur[j][DIVS_W-1:0];
          q_q[j]   <= {q_in[j][Q_W-2:0], 1'b0};
        end
      end
    end
  endgenerate

  localparam logic [Q_W-1:0] Q_CLAMP = {1'b1, {(Q_W-1){1'b0}}};

  // clamp the magnitude at 2^31
  assign out_valid = vld[DV_STEPS-1];
  assign quot = (ovf_q[DV_STEPS-1] || q_q[DV_STEPS-1][Q_W-1]) ? Q_CLAMP : q_q[DV_STEPS-1];

endmodule

// ----- hdl/rotation_matrix_to_quaternion.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion: Shepperd conversion of a Q2.30 matrix
// Fully pipelined: case select, square-root pipeline, three dividers.
//
//   channel  handshake      payload
//   input    start / busy   m00 m01 m02 m10 m11 m12 m20 m21 m22
//   result   strobe         quat_w quat_x quat_y quat_z case_used invalid
//
// A word is taken in every cycle; busy stays low.
// Each word passes through three front stages, the 32-stage square root, one
// prep stage, the 33-stage dividers and the output register before its result
// is on the ports.
// Synchronous reset clears all valid bits; words in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] m00,
  input  logic signed [DATA_W-1:0] m01,
  input  logic signed [DATA_W-1:0] m02,
  input  logic signed [DATA_W-1:0] m10,
  input  logic signed [DATA_W-1:0] m11,
  input  logic signed [DATA_W-1:0] m12,
  input  logic signed [DATA_W-1:0] m20,
  input  logic signed [DATA_W-1:0] m21,
  input  logic signed [DATA_W-1:0] m22,
  output logic                     strobe,
  output logic signed [DATA_W-1:0] quat_w,
  output logic signed [DATA_W-1:0] quat_x,
  output logic signed [DATA_W-1:0] quat_y,
  output logic signed [DATA_W-1:0] quat_z,
  output logic [1:0]               case_used,
  output logic                     invalid
);

  localparam logic signed [ARG_W-1:0] ONE = ARG_W'(1) << FRAC_BITS;

  typedef struct packed {
    case_t            sel;
    logic             bad;
    logic [2:0]       neg;
    logic [MAG_W-1:0] mag1;
    logic [MAG_W-1:0] mag2;
    logic [MAG_W-1:0] mag3;
  } sq_meta_t;

  typedef struct packed {
    case_t             sel;
    logic              bad;
    logic [2:0]        neg;
    logic [ROOT_W-1:0] chosen;
  } dv_meta_t;

  assign busy = 1'b0;

  // stage 0: capture the word
  logic                    s0_vld;
  logic signed [ARG_W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else begin
      s0_vld <= start;
    end
    a00 <= ARG_W'(m00);
    a01 <= ARG_W'(m01);
    a02 <= ARG_W'(m02);
    a10 <= ARG_W'(m10);
    a11 <= ARG_W'(m11);
    a12 <= ARG_W'(m12);
    a20 <= ARG_W'(m20);
    a21 <= ARG_W'(m21);
    a22 <= ARG_W'(m22);
  end

  // stage 1: trace, candidate arguments, diagonal compares, pair sums and differences
  logic                    s1_vld;
  logic signed [ARG_W-1:0] tr, arg0, arg1, arg2, arg3;
  logic signed [ARG_W-1:0] d21_12, d02_20, d10_01, p01_10, p02_20, p12_21;
  logic                    g00_11, g00_22, g11_22;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= s0_vld;
    end
    tr     <= a00 + a11 + a22;
    arg0   <= ONE + a00 + a11 + a22;
    arg1   <= ONE + a00 - a11 - a22;
    arg2   <= ONE + a11 - a00 - a22;
    arg3   <= ONE + a22 - a00 - a11;
    d21_12 <= a21 - a12;
    d02_20 <= a02 - a20;
    d10_01 <= a10 - a01;
    p01_10 <= a01 + a10;
    p02_20 <= a02 + a20;
    p12_21 <= a12 + a21;
    g00_11 <= a00 > a11;
    g00_22 <= a00 > a22;
    g11_22 <= a11 > a22;
  end

  // stage 2: pick the case, split numerators into sign and magnitude
  case_t                   sel_c;
  logic signed [ARG_W-1:0] arg_c, n1_c, n2_c, n3_c;

  always_comb begin
    if (tr > 0) begin
      sel_c = CASE_TRACE;
    end else if (g00_11 && g00_22) begin
      sel_c = CASE_X;
    end else if (g11_22) begin
      sel_c = CASE_Y;
    end else begin
      sel_c = CASE_Z;
    end
    unique case (sel_c)
      CASE_TRACE: begin
        arg_c = arg0; n1_c = d21_12; n2_c = d02_20; n3_c = d10_01;
      end
      CASE_X: begin
        arg_c = arg1; n1_c = d21_12; n2_c = p01_10; n3_c = p02_20;
      end
      CASE_Y: begin
        arg_c = arg2; n1_c = d02_20; n2_c = p01_10; n3_c = p12_21;
      end
      default: begin
        arg_c = arg3; n1_c = d10_01; n2_c = p02_20; n3_c = p12_21;
      end
    endcase
  end

  logic             s2_vld;
  sq_meta_t         s2_meta;
  logic [RAD_W-1:0] s2_rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    s2_meta.sel  <= sel_c;
    s2_meta.bad  <= arg_c[ARG_W-1] || (arg_c == '0);
    s2_meta.neg  <= {n3_c[ARG_W-1], n2_c[ARG_W-1], n1_c[ARG_W-1]};
    s2_meta.mag1 <= MAG_W'(n1_c[ARG_W-1] ? -n1_c : n1_c);
    s2_meta.mag2 <= MAG_W'(n2_c[ARG_W-1] ? -n2_c : n2_c);
    s2_meta.mag3 <= MAG_W'(n3_c[ARG_W-1] ? -n3_c : n3_c);
    s2_rad       <= RAD_W'(arg_c[MAG_W-1:0]) << FRAC_BITS;
  end

  // square root of arg * ONE
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;

  rmq_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_vld),
    .rad       (s2_rad),
    .out_valid (sq_vld),
    .root      (sq_root)
  );

  // carry the case data alongside the root
  sq_meta_t sq_line [SQ_STEPS];

  always_ff @(posedge clk) begin
    sq_line[0] <= s2_meta;
    for (int i = 1; i < SQ_STEPS; i++) begin
      sq_line[i] <= sq_line[i-1];
    end
  end

  // prep stage: dividends n*ONE + s/2 and divisor s = 2r
  sq_meta_t          sqm;
  logic              pp_vld;
  dv_meta_t          pp_meta;
  logic [DIVD_W-1:0] pp_dvd1, pp_dvd2, pp_dvd3;
  logic [DIVS_W-1:0] pp_s;

  assign sqm = sq_line[SQ_STEPS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      pp_vld <= 1'b0;
    end else begin
      pp_vld <= sq_vld;
    end
    pp_meta.sel    <= sqm.sel;
    pp_meta.bad    <= sqm.bad;
    pp_meta.neg    <= sqm.neg;
    pp_meta.chosen <= {1'b0, sq_root[ROOT_W-1:1]};
    pp_s           <= {sq_root, 1'b0};
    pp_dvd1        <= (DIVD_W'(sqm.mag1) << FRAC_BITS) + DIVD_W'(sq_root);
    pp_dvd2        <= (DIVD_W'(sqm.mag2) << FRAC_BITS) + DIVD_W'(sq_root);
    pp_dvd3        <= (DIVD_W'(sqm.mag3) << FRAC_BITS) + DIVD_W'(sq_root);
  end

  // three dividers in lockstep
  logic           dv_vld1, dv_vld2, dv_vld3;
  logic [Q_W-1:0] q1, q2, q3;

  rmq_div u_div1 (
    .clk (clk), .rst (rst), .in_valid (pp_vld),
    .dividend (pp_dvd1), .divisor (pp_s), .out_valid (dv_vld1), .quot (q1)
  );

  rmq_div u_div2 (
    .clk (clk), .rst (rst), .in_valid (pp_vld),
    .dividend (pp_dvd2), .divisor (pp_s), .out_valid (dv_vld2), .quot (q2)
  );

  rmq_div u_div3 (
    .clk (clk), .rst (rst), .in_valid (pp_vld),
    .dividend (pp_dvd3), .divisor (pp_s), .out_valid (dv_vld3), .quot (q3)
  );

  dv_meta_t dv_line [DV_LAT];

  always_ff @(posedge clk) begin
    dv_line[0] <= pp_meta;
    for (int i = 1; i < DV_LAT; i++) begin
      dv_line[i] <= dv_line[i-1];
    end
  end

  // final stage: apply signs, saturate, place the chosen component
  localparam logic signed [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};

  function automatic logic signed [DATA_W-1:0] apply_sign(logic neg, logic [Q_W-1:0] mag);
    logic signed [DATA_W-1:0] res;
    if (neg) begin
      res = -$signed(mag);
    end else if (mag[Q_W-1]) begin
      res = SAT_POS;
    end else begin
      res = $signed(mag);
    end
    return res;
  endfunction

  dv_meta_t                 dvm;
  logic signed [DATA_W-1:0] o1, o2, o3, ch;
  logic signed [DATA_W-1:0] w_c, x_c, y_c, z_c;

  assign dvm = dv_line[DV_LAT-1];
  assign o1  = apply_sign(dvm.neg[0], q1);
  assign o2  = apply_sign(dvm.neg[1], q2);
  assign o3  = apply_sign(dvm.neg[2], q3);
  assign ch  = $signed(dvm.chosen);

  always_comb begin
    unique case (dvm.sel)
      CASE_TRACE: begin w_c = ch; x_c = o1; y_c = o2; z_c = o3; end
      CASE_X:     begin w_c = o1; x_c = ch; y_c = o2; z_c = o3; end
      CASE_Y:     begin w_c = o1; x_c = o2; y_c = ch; z_c = o3; end
      default:    begin w_c = o1; x_c = o2; y_c = o3; z_c = ch; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= dv_vld1 && dv_vld2 && dv_vld3;
    end
    quat_w    <= dvm.bad ? '0 : w_c;
    quat_x    <= dvm.bad ? '0 : x_c;
    quat_y    <= dvm.bad ? '0 : y_c;
    quat_z    <= dvm.bad ? '0 : z_c;
    case_used <= dvm.sel;
    invalid   <= dvm.bad;
  end

  // checks
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LATENCY strobe)
    else $error("result word missing after fixed latency");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start, LATENCY))
    else $error("result word without an accepted input word");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && invalid |-> quat_w == 0 && quat_x == 0 && quat_y == 0 && quat_z == 0)
    else $error("invalid result with nonzero quaternion");

  a_trace_w: assert property (@(posedge clk) disable iff (rst)
    strobe && !invalid && case_used == CASE_TRACE |-> !quat_w[DATA_W-1])
    else $error("negative scalar part in trace case");

endmodule
